### src/adf_pkg.sv
`default_nettype none

package adf_pkg;

  localparam int HEADER_BYTES = 7;
  localparam int STORE_BYTES  = HEADER_BYTES - 1;
  localparam int LEN_W        = 13;
  localparam int HIDX_W       = 3;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 13'd8191;
  localparam logic [7:0]       SYNC_BYTE       = 8'hFF;
  localparam logic [3:0]       SYNC_NIBBLE     = 4'hF;

  typedef enum logic [1:0] {
    KIND_FRAME     = 2'd0,
    KIND_BAD_SYNC  = 2'd1,
    KIND_TOO_LONG  = 2'd2,
    KIND_TOO_SHORT = 2'd3
  } adf_kind_e;

  // Decoded header fields
  typedef struct packed {
    logic [LEN_W-1:0] frame_length;
    logic             mpeg_id;
    logic             crc_absent;
    logic [1:0]       audio_profile;
    logic [3:0]       rate_index;
    logic [2:0]       channel_layout;
    logic [10:0]      fullness;
    logic [1:0]       raw_block_count;
  } adf_hdr_t;

  // One queue entry: a single result, or a header replay of seven results
  typedef struct packed {
    adf_kind_e                        kind;
    logic                             replay;
    logic                             show_hdr;
    logic                             last;
    logic [HEADER_BYTES-1:0][7:0]     bytes;
  } adf_cmd_t;

  function automatic adf_hdr_t adf_decode(input logic [HEADER_BYTES-1:0][7:0] b);
    adf_hdr_t r;
    r.frame_length    = {b[3][1:0], b[4], b[5][7:5]};
    r.mpeg_id         = b[1][3];
    r.crc_absent      = b[1][0];
    r.audio_profile   = b[2][7:6];
    r.rate_index      = b[2][5:2];
    r.channel_layout  = {b[2][0], b[3][7:6]};
    r.fullness        = {b[5][4:0], b[6][7:2]};
    r.raw_block_count = b[6][1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### src/adf_front.sv
`default_nettype none

module adf_front import adf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [LEN_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output adf_cmd_t              cmd_o
);

  logic [STORE_BYTES-1:0][7:0] hdr_q;
  logic [HIDX_W-1:0]           count_q, count_d;
  logic                        in_payload_q, in_payload_d;
  logic [LEN_W-1:0]            bytes_left_q, bytes_left_d;
  logic [LEN_W-1:0]            max_q;
  logic [LEN_W-1:0]            len;
  logic                        take;
  logic                        store_en;
  logic                        sync_ok;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o;
  assign len        = {hdr_q[3][1:0], hdr_q[4], hdr_q[5][7:5]};
  assign sync_ok    = (hdr_q[0] == SYNC_BYTE) && (hdr_q[1][7:4] == SYNC_NIBBLE);
  assign store_en   = take && !in_payload_q && (count_q < HIDX_W'(STORE_BYTES));

  always_comb begin
    count_d      = count_q;
    in_payload_d = in_payload_q;
    bytes_left_d = bytes_left_q;
    push_o       = 1'b0;
    cmd_o        = '0;
    cmd_o.kind   = KIND_FRAME;
    if (take) begin
      if (in_payload_q) begin
        // pass one payload byte
        push_o                     = 1'b1;
        bytes_left_d               = bytes_left_q - 1'b1;
        cmd_o.bytes[HEADER_BYTES-1] = data_byte_i;
        cmd_o.last                 = (bytes_left_q == LEN_W'(1));
        if (cmd_o.last) begin
          in_payload_d = 1'b0;
        end
      end else if (store_en) begin
        count_d = count_q + 1'b1;
      end else begin
        count_d    = '0;
        push_o     = 1'b1;
        cmd_o.last = 1'b1;
        for (int i = 0; i < STORE_BYTES; i++) begin
          cmd_o.bytes[i] = hdr_q[i];
        end
        cmd_o.bytes[HEADER_BYTES-1] = data_byte_i;
        if (!sync_ok) begin
          cmd_o.kind = KIND_BAD_SYNC;
        end else if (len > max_q) begin
          cmd_o.kind     = KIND_TOO_LONG;
          cmd_o.show_hdr = 1'b1;
        end else if (len < LEN_W'(HEADER_BYTES)) begin
          cmd_o.kind     = KIND_TOO_SHORT;
          cmd_o.show_hdr = 1'b1;
        end else begin
          cmd_o.replay   = 1'b1;
          cmd_o.show_hdr = 1'b1;
          cmd_o.last     = (len == LEN_W'(HEADER_BYTES));
          if (len > LEN_W'(HEADER_BYTES)) begin
            bytes_left_d = len - LEN_W'(HEADER_BYTES);
            in_payload_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      in_payload_q <= 1'b0;
      bytes_left_q <= '0;
      max_q        <= MAX_FRAME_RESET;
    end else begin
      count_q      <= count_d;
      in_payload_q <= in_payload_d;
      bytes_left_q <= bytes_left_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      hdr_q[count_q] <= data_byte_i;
    end
  end

endmodule

`default_nettype wire

### src/adf_queue.sv
`default_nettype none

module adf_queue import adf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire adf_cmd_t cmd_i,
  output logic          full_o,
  output logic          head_valid_o,
  output adf_cmd_t      head_o,
  input  wire logic     pop_i
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  adf_cmd_t          mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     cnt_q;

  assign full_o       = (cnt_q == CW'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

### src/adf_back.sv
`default_nettype none

module adf_back import adf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     head_valid_i,
  input  wire adf_cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output adf_kind_e     kind_o,
  output logic [7:0]    out_byte_o,
  output logic          first_o,
  output logic          last_o,
  output adf_hdr_t      hdr_o
);

  logic [HIDX_W-1:0] cnt_q;
  logic              out_valid_q;
  adf_kind_e         kind_q;
  logic [7:0]        byte_q;
  logic              first_q, last_q;
  adf_hdr_t          hdr_q;
  logic              issue, last_step;
  logic [7:0]        byte_d;
  adf_hdr_t          hdr_d;

  assign issue     = head_valid_i && (!out_valid_q || out_ready_i);
  assign last_step = !head_i.replay || (cnt_q == HIDX_W'(HEADER_BYTES - 1));
  assign pop_o     = issue && last_step;

  always_comb begin
    if (head_i.replay) begin
      byte_d = head_i.bytes[cnt_q];
    end else if (head_i.kind == KIND_FRAME) begin
      byte_d = head_i.bytes[HEADER_BYTES-1];
    end else begin
      byte_d = '0;
    end
    hdr_d = head_i.show_hdr ? adf_decode(head_i.bytes) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        cnt_q       <= last_step ? '0 : cnt_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      kind_q  <= head_i.kind;
      byte_q  <= byte_d;
      first_q <= head_i.replay && (cnt_q == '0);
      last_q  <= head_i.replay ? (last_step && head_i.last) : head_i.last;
      hdr_q   <= hdr_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign out_byte_o  = byte_q;
  assign first_o     = first_q;
  assign last_o      = last_q;
  assign hdr_o       = hdr_q;

endmodule

`default_nettype wire

### src/adts_frame_deframer.sv
// A payload byte passes through the queue and then the back end's output register.
// A good header takes the same path after its seventh byte; its seven header bytes
// then leave one after another as the output takes them.
// Bytes are taken one per cycle while the queue is not full; each good header
// is replayed from the single output register of the back end.
// Reset: asynchronous, active low; clears all control state and sets the maximum
// frame length register to 8191. No clearing pass is needed.
`default_nettype none

module adts_frame_deframer import adf_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration: maximum frame length
  input  wire logic             cfg_we_i,
  input  wire logic [LEN_W-1:0] cfg_wdata_i,
  // byte stream in
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       data_byte_i,
  // results out
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            kind_o,
  output logic [7:0]            out_byte_o,
  output logic                  first_of_frame_o,
  output logic                  last_of_frame_o,
  output logic [LEN_W-1:0]      frame_length_o,
  output logic                  mpeg_id_o,
  output logic                  crc_absent_o,
  output logic [1:0]            audio_profile_o,
  output logic [3:0]            rate_index_o,
  output logic [2:0]            channel_layout_o,
  output logic [10:0]           fullness_o,
  output logic [1:0]            raw_block_count_o
);

  // Front end: collect header bytes, check sync and length, track payload count.
  // Every transfer that yields results pushes one command into the queue.
  logic      q_full, push, head_valid, pop;
  adf_cmd_t  cmd, head;
  adf_kind_e kind;
  adf_hdr_t  hdr;

  adf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  // Short queue decouples the front from the replay; the front keeps taking
  // payload bytes until it fills.
  adf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Back end: expand a header command into seven results, otherwise emit one;
  // hold the result in the output register until it is taken.
  adf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind),
    .out_byte_o   (out_byte_o),
    .first_o      (first_of_frame_o),
    .last_o       (last_of_frame_o),
    .hdr_o        (hdr)
  );

  assign kind_o            = kind;
  assign frame_length_o    = hdr.frame_length;
  assign mpeg_id_o         = hdr.mpeg_id;
  assign crc_absent_o      = hdr.crc_absent;
  assign audio_profile_o   = hdr.audio_profile;
  assign rate_index_o      = hdr.rate_index;
  assign channel_layout_o  = hdr.channel_layout;
  assign fullness_o        = hdr.fullness;
  assign raw_block_count_o = hdr.raw_block_count;

endmodule

`default_nettype wire

### src/adf_checker.sv
`default_nettype none

module adf_checker import adf_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [1:0]       kind_o,
  input wire logic [7:0]       out_byte_o,
  input wire logic             first_of_frame_o,
  input wire logic             last_of_frame_o,
  input wire logic [LEN_W-1:0] frame_length_o,
  input wire logic [10:0]      fullness_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(kind_o))
    else $error("stalled result changed");

  a_first_is_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_of_frame_o |-> kind_o == KIND_FRAME && !last_of_frame_o)
    else $error("frame start on an error result");

  a_error_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_FRAME |-> last_of_frame_o && out_byte_o == 8'd0)
    else $error("error result not final or carries a byte");

  a_bad_sync_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_BAD_SYNC |-> frame_length_o == '0 && fullness_o == '0)
    else $error("bad sync result carries header fields");

endmodule

bind adts_frame_deframer adf_checker u_adf_checker (.*);

`default_nettype wire
